[design/bhr_pkg.sv]
// Shared types, constants and arithmetic helpers for the balanced HSV to RGB converter.
`timescale 1ns / 1ps
package bhr_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CH_W         = FRAC_BITS + 1;
   localparam int FREQ_W       = 24;
   localparam int FREQ_FRAC    = 8;
   localparam int MANT_BITS    = 30;
   localparam int MANT_W       = MANT_BITS + 1;
   localparam int POS_W        = $clog2(FREQ_W);
   localparam int NLOG_W       = FRAC_BITS + $clog2(FRAC_BITS + 1);
   localparam int WHOLE_W      = NLOG_W - FRAC_BITS;
   localparam int LOG_STAGES   = FRAC_BITS;
   localparam int EXP_STAGES   = FRAC_BITS;
   localparam int SQ_PER_STAGE = 3;
   localparam int SQ_STAGES    = (FRAC_BITS + SQ_PER_STAGE) / SQ_PER_STAGE;
   localparam int SQ_ROOT_W    = SQ_STAGES * SQ_PER_STAGE;
   localparam int SQ_IN_W      = 2 * SQ_ROOT_W;
   localparam int SQ_REM_W     = SQ_ROOT_W + 3;
   localparam int NUM_CH       = 3;
   localparam int SQ_LANES     = NUM_CH + 1;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_BIT  = 2;

   localparam logic [CH_W-1:0]      ONE       = CH_W'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] HALF      = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [MANT_W-1:0]    MANT_ONE  = MANT_W'(1) << MANT_BITS;
   localparam logic [FRAC_BITS-1:0] OFS_RED   = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [FRAC_BITS-1:0] OFS_GREEN = FRAC_BITS'(((1 << FRAC_BITS) + 3) / 6);
   localparam logic [FRAC_BITS-1:0] OFS_BLUE  = FRAC_BITS'((5 * (1 << FRAC_BITS) + 3) / 6);
   localparam logic [NUM_CH-1:0][FRAC_BITS-1:0] CH_OFFSET = {OFS_BLUE, OFS_GREEN, OFS_RED};

   localparam logic [CH_W-1:0] PITCH_SAT_RESET = ONE;
   localparam logic [CH_W-1:0] PITCH_VAL_RESET = ONE >> 1;

   localparam logic CMD_HSV  = 1'b0;
   localparam logic CMD_FREQ = 1'b1;

   typedef enum logic {
      REG_PITCH_SAT = 1'b0,
      REG_PITCH_VAL = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic                 command;
      logic [FRAC_BITS-1:0] hue;
      logic [CH_W-1:0]      saturation;
      logic [CH_W-1:0]      brightness;
      logic [FREQ_W-1:0]    frequency;
   } pixel_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_rsp_type;

   typedef struct packed {
      logic [MANT_W-1:0]    mant_f;
      logic [MANT_W-1:0]    mant_v;
      logic [FRAC_BITS-1:0] log_f;
      logic [FRAC_BITS-1:0] log_v;
      logic                 use_freq;
      logic                 freq_low;
      logic [FRAC_BITS-1:0] hue;
      logic [POS_W-1:0]     top_v;
      logic [CH_W-1:0]      sat;
      logic [CH_W-1:0]      val;
   } log_data_type;

   typedef struct packed {
      logic [SQ_IN_W-1:0]   rad;
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_lane_type;

   typedef struct packed {
      sq_lane_type [SQ_LANES-1:0]     lane;
      logic [NUM_CH-1:0][CH_W-1:0]    ramp;
      logic [NLOG_W-1:0]              neg_log;
      logic [CH_W-1:0]                sat;
      logic [CH_W-1:0]                val;
   } sqrt_data_type;

   typedef struct packed {
      logic [CH_W-1:0]             gamma;
      logic [NUM_CH-1:0][CH_W-1:0] p15;
      logic [NLOG_W-1:0]           neg_log;
      logic [CH_W-1:0]             sat;
      logic [CH_W-1:0]             val;
   } gamma_data_type;

   typedef struct packed {
      logic [MANT_W-1:0]           acc;
      logic [FRAC_BITS-1:0]        frac;
      logic [WHOLE_W-1:0]          whole;
      logic [NUM_CH-1:0][CH_W-1:0] mix;
      logic [CH_W-1:0]             val;
   } exp_data_type;

   typedef struct packed {
      logic [CH_W-1:0]             factor;
      logic [NUM_CH-1:0][CH_W-1:0] mix;
      logic [CH_W-1:0]             val;
   } scale_data_type;

   typedef logic [MANT_W-1:0] root_table_type [EXP_STAGES];

   function automatic logic [CH_W-1:0] clamp_one(input logic [CH_W-1:0] x);
      return (x > ONE) ? ONE : x;
   endfunction

   function automatic logic [POS_W-1:0] top_bit(input logic [FREQ_W-1:0] x);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < FREQ_W; i++) begin
         if (x[i]) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   // Elaboration-time floor square root.
   function automatic longint unsigned isqrt64(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      longint unsigned v;
      r = 0;
      b = 64'd1 << 62;
      v = x;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(i+1)) in Q0.30 by repeated square roots of one half.
   function automatic root_table_type exp2_roots();
      root_table_type  t;
      longint unsigned c;
      c = 64'd1 << (MANT_BITS - 1);
      for (int i = 0; i < EXP_STAGES; i++) begin
         c = isqrt64(c << MANT_BITS);
         t[i] = MANT_W'(c);
      end
      return t;
   endfunction

   localparam root_table_type EXP2_ROOTS = exp2_roots();

   // One squaring step of the log2 fraction for both mantissas.
   function automatic log_data_type log_step(input log_data_type d);
      log_data_type          n;
      logic [2*MANT_W-1:0]   sq_f;
      logic [2*MANT_W-1:0]   sq_v;
      n = d;
      sq_f = {{MANT_W{1'b0}}, d.mant_f} * {{MANT_W{1'b0}}, d.mant_f};
      sq_v = {{MANT_W{1'b0}}, d.mant_v} * {{MANT_W{1'b0}}, d.mant_v};
      n.log_f = {d.log_f[FRAC_BITS-2:0], sq_f[2*MANT_W-1]};
      n.log_v = {d.log_v[FRAC_BITS-2:0], sq_v[2*MANT_W-1]};
      n.mant_f = sq_f[2*MANT_W-1] ? sq_f[2*MANT_W-1 -: MANT_W] : sq_f[2*MANT_W-2 -: MANT_W];
      n.mant_v = sq_v[2*MANT_W-1] ? sq_v[2*MANT_W-1 -: MANT_W] : sq_v[2*MANT_W-2 -: MANT_W];
      return n;
   endfunction

   // One digit of a restoring square root.
   function automatic sq_lane_type sqrt_step(input sq_lane_type l);
      sq_lane_type           n;
      logic [SQ_REM_W-1:0]   rem;
      logic [SQ_REM_W-1:0]   trial;
      rem   = {l.rem[SQ_REM_W-3:0], l.rad[SQ_IN_W-1 -: 2]};
      trial = SQ_REM_W'({l.root, 2'b01});
      n.rad = {l.rad[SQ_IN_W-3:0], 2'b00};
      if (rem >= trial) begin
         n.rem  = rem - trial;
         n.root = {l.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = rem;
         n.root = {l.root[SQ_ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   function automatic sqrt_data_type sqrt_stage(input sqrt_data_type d);
      sqrt_data_type n;
      n = d;
      for (int k = 0; k < SQ_PER_STAGE; k++) begin
         for (int l = 0; l < SQ_LANES; l++) begin
            n.lane[l] = sqrt_step(n.lane[l]);
         end
      end
      return n;
   endfunction

   function automatic exp_data_type exp_step(input exp_data_type d,
                                             input logic [MANT_W-1:0] root);
      exp_data_type        n;
      logic [2*MANT_W-1:0] prod;
      n = d;
      prod = {{MANT_W{1'b0}}, d.acc} * {{MANT_W{1'b0}}, root};
      if (d.frac[FRAC_BITS-1]) begin
         n.acc = prod[2*MANT_W-2 -: MANT_W];
      end
      n.frac = {d.frac[FRAC_BITS-2:0], 1'b0};
      return n;
   endfunction

   // Clamped triangle ramp of one channel.
   function automatic logic [CH_W-1:0] hue_ramp(input logic [FRAC_BITS-1:0] hue,
                                                input logic [FRAC_BITS-1:0] ofs);
      logic [FRAC_BITS-1:0] t;
      logic [FRAC_BITS-1:0] d;
      logic [FRAC_BITS+2:0] six;
      logic [FRAC_BITS+2:0] over;
      t = hue + ofs;
      d = (t >= HALF) ? t - HALF : HALF - t;
      six = (FRAC_BITS+3)'(d) * (FRAC_BITS+3)'(6);
      over = six - (FRAC_BITS+3)'(ONE);
      if (six <= (FRAC_BITS+3)'(ONE)) begin
         return '0;
      end else if (over > (FRAC_BITS+3)'(ONE)) begin
         return ONE;
      end else begin
         return over[CH_W-1:0];
      end
   endfunction

endpackage

[design/bhr_log2_pipe.sv]
// Log2 fraction pipeline: one mantissa squaring per stage for the frequency and brightness mantissas.
`timescale 1ns / 1ps
module bhr_log2_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  bhr_pkg::log_data_type in_data,
   output logic                  out_valid,
   output bhr_pkg::log_data_type out_data
);
   import bhr_pkg::*;

   logic [LOG_STAGES-1:0] valid_ff;
   log_data_type          stage_ff [LOG_STAGES];
   log_data_type          stage_in [LOG_STAGES];

   for (genvar g = 0; g < LOG_STAGES; g++) begin : g_stage
      log_data_type src;
      if (g == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stage_ff[g-1];
      end
      assign stage_in[g] = log_step(src);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LOG_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[LOG_STAGES-1];
   assign out_data  = stage_ff[LOG_STAGES-1];

endmodule

[design/bhr_sqrt_pipe.sv]
// Square root pipeline: four lanes, three root digits per stage.
`timescale 1ns / 1ps
module bhr_sqrt_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  bhr_pkg::sqrt_data_type in_data,
   output logic                   out_valid,
   output bhr_pkg::sqrt_data_type out_data
);
   import bhr_pkg::*;

   logic [SQ_STAGES-1:0] valid_ff;
   sqrt_data_type        stage_ff [SQ_STAGES];
   sqrt_data_type        stage_in [SQ_STAGES];

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
      sqrt_data_type src;
      if (g == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stage_ff[g-1];
      end
      assign stage_in[g] = sqrt_stage(src);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[SQ_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[SQ_STAGES-1];
   assign out_data  = stage_ff[SQ_STAGES-1];

endmodule

[design/bhr_exp2_pipe.sv]
// Power-of-two pipeline: one conditional multiply by a root of one half per stage.
`timescale 1ns / 1ps
module bhr_exp2_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  bhr_pkg::exp_data_type in_data,
   output logic                  out_valid,
   output bhr_pkg::exp_data_type out_data
);
   import bhr_pkg::*;

   logic [EXP_STAGES-1:0] valid_ff;
   exp_data_type          stage_ff [EXP_STAGES];
   exp_data_type          stage_in [EXP_STAGES];

   for (genvar g = 0; g < EXP_STAGES; g++) begin : g_stage
      exp_data_type src;
      if (g == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stage_ff[g-1];
      end
      assign stage_in[g] = exp_step(src, EXP2_ROOTS[g]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[EXP_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[EXP_STAGES-1];
   assign out_data  = stage_ff[EXP_STAGES-1];

endmodule

[design/balanced_hsv_to_rgb.sv]
// Top level of the balanced HSV to RGB converter: stage glue, CSRs and result register.
`timescale 1ns / 1ps
// Takes one item per clock unless the pipeline holds. The pipeline is built from the two
// 16-stage multiply chains (log2 by mantissa squaring, then 2^-x by a product of roots of
// one half) with a 6-stage square root between them. The whole pipeline holds while a
// finished item waits on rsp_ready, so req_ready drops only in that case.
// pitch_saturation sits at byte address 0 and pitch_value at 4.
module balanced_hsv_to_rgb (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bhr_pkg::pixel_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bhr_pkg::pixel_rsp_type            rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bhr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bhr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bhr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bhr_pkg::*;

   logic            advance;
   logic            csr_write;
   csr_reg_type     csr_index;
   logic [CH_W-1:0] pitch_sat_ff;
   logic [CH_W-1:0] pitch_val_ff;

   // Stage registers
   logic           s0_valid_ff;
   log_data_type   s0_ff;
   log_data_type   s0_in;
   logic           lg_valid;
   log_data_type   lg_data;
   logic           sh_valid_ff;
   sqrt_data_type  sh_ff;
   sqrt_data_type  sh_in;
   logic           sq_valid;
   sqrt_data_type  sq_data;
   logic           g1_valid_ff;
   gamma_data_type g1_ff;
   gamma_data_type g1_in;
   logic           g2_valid_ff;
   exp_data_type   g2_ff;
   exp_data_type   g2_in;
   logic           ex_valid;
   exp_data_type   ex_data;
   logic           sx_valid_ff;
   scale_data_type sx_ff;
   scale_data_type sx_in;
   logic           sv_valid_ff;
   scale_data_type sv_ff;
   scale_data_type sv_in;
   logic           rsp_valid_ff;
   pixel_rsp_type  rsp_data_ff;
   pixel_rsp_type  rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_IDX_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_sat_ff <= PITCH_SAT_RESET;
         pitch_val_ff <= PITCH_VAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PITCH_SAT: pitch_sat_ff <= csr_pwdata[CH_W-1:0];
            REG_PITCH_VAL: pitch_val_ff <= csr_pwdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PITCH_SAT: csr_prdata = CSR_DATA_W'(pitch_sat_ff);
         REG_PITCH_VAL: csr_prdata = CSR_DATA_W'(pitch_val_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Input stage: pick operands and normalize mantissas
   always_comb begin
      logic [CH_W-1:0]  sat_sel;
      logic [CH_W-1:0]  val_sel;
      logic [POS_W-1:0] top_f;
      s0_in          = '0;
      s0_in.use_freq = (req_data.command == CMD_FREQ);
      sat_sel        = s0_in.use_freq ? pitch_sat_ff : req_data.saturation;
      val_sel        = s0_in.use_freq ? pitch_val_ff : req_data.brightness;
      s0_in.sat      = clamp_one(sat_sel);
      s0_in.val      = clamp_one(val_sel);
      s0_in.hue      = req_data.hue;
      s0_in.freq_low = (req_data.frequency[FREQ_W-1:FREQ_FRAC] == '0);
      top_f          = top_bit(req_data.frequency);
      s0_in.top_v    = top_bit(FREQ_W'(s0_in.val));
      s0_in.mant_f   = MANT_W'(req_data.frequency) << (MANT_BITS - int'(top_f));
      s0_in.mant_v   = MANT_W'(s0_in.val) << (MANT_BITS - int'(s0_in.top_v));
   end

   bhr_log2_pipe u_log2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_data   (s0_ff),
      .out_valid (lg_valid),
      .out_data  (lg_data)
   );

   // Hue select, ramps and square root operands
   always_comb begin
      logic [FRAC_BITS-1:0] hue;
      hue = lg_data.use_freq ? (lg_data.freq_low ? '0 : lg_data.log_f) : lg_data.hue;
      sh_in         = '0;
      sh_in.sat     = lg_data.sat;
      sh_in.val     = lg_data.val;
      sh_in.neg_log = (NLOG_W'(FRAC_BITS - int'(lg_data.top_v)) << FRAC_BITS)
                      - NLOG_W'(lg_data.log_v);
      sh_in.lane[0].rad = SQ_IN_W'(hue) << FRAC_BITS;
      for (int c = 0; c < NUM_CH; c++) begin
         sh_in.ramp[c]       = hue_ramp(hue, CH_OFFSET[c]);
         sh_in.lane[c+1].rad = SQ_IN_W'(sh_in.ramp[c]) << FRAC_BITS;
      end
   end

   bhr_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sh_valid_ff),
      .in_data   (sh_ff),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   // Gamma and ramp^1.5
   always_comb begin
      logic [FRAC_BITS-1:0] u;
      logic [CH_W-1:0]      two_u;
      logic [CH_W-1:0]      g0;
      logic [2*CH_W-1:0]    prod;
      u     = sq_data.lane[0].root[FRAC_BITS-1:0] + HALF;
      two_u = {u, 1'b0};
      g0    = (two_u >= ONE) ? two_u - ONE : ONE - two_u;
      prod  = (2*CH_W)'(g0) * (2*CH_W)'(sq_data.sat);
      g1_in.gamma   = prod[FRAC_BITS +: CH_W];
      g1_in.neg_log = sq_data.neg_log;
      g1_in.sat     = sq_data.sat;
      g1_in.val     = sq_data.val;
      for (int c = 0; c < NUM_CH; c++) begin
         g1_in.p15[c] = CH_W'(((2*CH_W)'(sq_data.ramp[c])
                        * (2*CH_W)'(sq_data.lane[c+1].root[CH_W-1:0])) >> FRAC_BITS);
      end
   end

   // Exponent and saturation mix
   always_comb begin
      logic [CH_W+NLOG_W-1:0] e_prod;
      logic [2*CH_W-1:0]      m_prod;
      e_prod      = (CH_W+NLOG_W)'(g1_ff.gamma) * (CH_W+NLOG_W)'(g1_ff.neg_log);
      g2_in.acc   = MANT_ONE;
      g2_in.frac  = e_prod[FRAC_BITS +: FRAC_BITS];
      g2_in.whole = e_prod[2*FRAC_BITS +: WHOLE_W];
      g2_in.val   = g1_ff.val;
      for (int c = 0; c < NUM_CH; c++) begin
         m_prod       = (2*CH_W)'(g1_ff.p15[c]) * (2*CH_W)'(g1_ff.sat);
         g2_in.mix[c] = ONE - m_prod[FRAC_BITS +: CH_W];
      end
   end

   bhr_exp2_pipe u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (g2_valid_ff),
      .in_data   (g2_ff),
      .out_valid (ex_valid),
      .out_data  (ex_data)
   );

   // Drop the mantissa to Q1.F by the integer part of the exponent
   always_comb begin
      logic [MANT_W-1:0] shifted;
      shifted      = ex_data.acc >> ((MANT_BITS - FRAC_BITS) + int'(ex_data.whole));
      sx_in.factor = shifted[CH_W-1:0];
      sx_in.mix    = ex_data.mix;
      sx_in.val    = ex_data.val;
   end

   // Brightness scale v^(1+gamma)
   always_comb begin
      logic [2*CH_W-1:0] prod;
      prod      = (2*CH_W)'(sx_ff.val) * (2*CH_W)'(sx_ff.factor);
      sv_in.mix = sx_ff.mix;
      sv_in.val = sx_ff.val;
      if (sx_ff.val == '0) begin
         sv_in.factor = '0;
      end else if (sx_ff.val >= ONE) begin
         sv_in.factor = ONE;
      end else begin
         sv_in.factor = prod[FRAC_BITS +: CH_W];
      end
   end

   // Final channel scaling
   always_comb begin
      logic [NUM_CH-1:0][CH_W-1:0] ch;
      logic [2*CH_W-1:0]           prod;
      for (int c = 0; c < NUM_CH; c++) begin
         prod  = (2*CH_W)'(sv_ff.mix[c]) * (2*CH_W)'(sv_ff.factor);
         ch[c] = clamp_one(prod[FRAC_BITS +: CH_W]);
      end
      rsp_data_in.red   = ch[0];
      rsp_data_in.green = ch[1];
      rsp_data_in.blue  = ch[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         sh_valid_ff  <= 1'b0;
         g1_valid_ff  <= 1'b0;
         g2_valid_ff  <= 1'b0;
         sx_valid_ff  <= 1'b0;
         sv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         sh_valid_ff  <= lg_valid;
         g1_valid_ff  <= sq_valid;
         g2_valid_ff  <= g1_valid_ff;
         sx_valid_ff  <= ex_valid;
         sv_valid_ff  <= sx_valid_ff;
         rsp_valid_ff <= sv_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff       <= s0_in;
         sh_ff       <= sh_in;
         g1_ff       <= g1_in;
         g2_ff       <= g2_in;
         sx_ff       <= sx_in;
         sv_ff       <= sv_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/bhr_checker.sv]
// Port-level checks for the balanced HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
module bhr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input bhr_pkg::pixel_rsp_type            rsp_data
);
   import bhr_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A blocked result halts the whole pipeline, input included
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result blocked");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.red <= ONE && rsp_data.green <= ONE && rsp_data.blue <= ONE)
      else $error("channel above one");

endmodule

bind balanced_hsv_to_rgb bhr_checker u_bhr_checker (.*);

[dv/balanced_hsv_to_rgb_tb.sv]
// Self-checking testbench for the balanced HSV to RGB converter.
`timescale 1ns / 1ps
module balanced_hsv_to_rgb_tb;
   import bhr_pkg::*;

   localparam int LATENCY     = 45;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_RANDOM  = 500;
   localparam longint unsigned F1 = 64'd1 << 16;
   localparam longint unsigned M1 = 64'd1 << 30;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   pixel_req_type req_data;
   pixel_rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   balanced_hsv_to_rgb dut (.*);

   pixel_rsp_type colour_queue[$];
   longint unsigned cfg_sat, cfg_val;
   int errors = 0;
   int cycles = 0;
   int results_seen = 0;
   bit hold_rsp = 0;
   bit long_hold = 0;
   bit hold_done = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint unsigned isqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int msb(input longint unsigned x);
      int p;
      p = -1;
      while (x != 0) begin
         x >>= 1;
         p++;
      end
      return p;
   endfunction

   function automatic longint unsigned sat1(input longint unsigned x);
      return x > F1 ? F1 : x;
   endfunction

   function automatic longint unsigned log2_frac(input longint unsigned m, input int p);
      longint unsigned x, res;
      res = 0;
      x = (p <= 30) ? (m << (30 - p)) : (m >> (p - 30));
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         res <<= 1;
         if (x >= (M1 << 1)) begin
            res |= 1;
            x >>= 1;
         end
      end
      return res;
   endfunction

   function automatic longint unsigned pow2_neg(input longint unsigned e);
      longint unsigned k, f, acc, c, sh;
      k = e >> 16;
      f = e & (F1 - 1);
      acc = M1;
      c = M1 >> 1;
      for (int i = 1; i <= 16; i++) begin
         c = isqrt(c << 30);
         if ((f >> (16 - i)) & 1) acc = (acc * c) >> 30;
      end
      sh = 14 + k;
      if (sh >= 63) return 0;
      return acc >> sh;
   endfunction

   function automatic longint unsigned bright_scale(input longint unsigned v,
                                                    input longint unsigned g);
      int p;
      longint unsigned nl;
      if (v == 0) return 0;
      if (v >= F1) return F1;
      p = msb(v);
      nl = (longint'(16 - p) << 16) - log2_frac(v, p);
      return (v * pow2_neg((g * nl) >> 16)) >> 16;
   endfunction

   function automatic logic [CH_W-1:0] chan(input longint unsigned h, ofs, s, sc);
      longint unsigned t, d, r, p15, mix;
      t = (h + ofs) & (F1 - 1);
      d = t >= (F1 >> 1) ? t - (F1 >> 1) : (F1 >> 1) - t;
      r = (6 * d <= F1) ? 0 : sat1(6 * d - F1);
      p15 = (r * isqrt(r << 16)) >> 16;
      mix = F1 - ((p15 * s) >> 16);
      return CH_W'(sat1((mix * sc) >> 16));
   endfunction

   function automatic pixel_rsp_type colour_of(input pixel_req_type px);
      longint unsigned h, s, v, q, u, g0, sc, fr;
      pixel_rsp_type o;
      if (px.command == CMD_HSV) begin
         h = px.hue;
         s = sat1(px.saturation);
         v = sat1(px.brightness);
      end else begin
         fr = px.frequency;
         h = fr < 256 ? 0 : log2_frac(fr, msb(fr));
         s = sat1(cfg_sat);
         v = sat1(cfg_val);
      end
      q = isqrt(h << 16);
      u = (q + (F1 >> 1)) & (F1 - 1);
      g0 = (2 * u >= F1) ? 2 * u - F1 : F1 - 2 * u;
      sc = bright_scale(v, (g0 * s) >> 16);
      o.red   = chan(h, F1 >> 1, s, sc);
      o.green = chan(h, (F1 + 3) / 6, s, sc);
      o.blue  = chan(h, (5 * F1 + 3) / 6, s, sc);
      return o;
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   int hold_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (long_hold && !hold_done) begin
         rsp_ready <= 0;
         hold_count <= hold_count + 1;
         if (hold_count >= 200) begin
            hold_done <= 1;
         end
      end else if (hold_rsp) begin
         rsp_ready <= 1;
      end else begin
         rsp_ready <= (cycles % 97 < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (colour_queue.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            pixel_rsp_type ex;
            ex = colour_queue.pop_front();
            if (rsp_data.red !== ex.red)
               $display("%0t red exp %h got %h", $time, ex.red, rsp_data.red);
            if (rsp_data.green !== ex.green)
               $display("%0t green exp %h got %h", $time, ex.green, rsp_data.green);
            if (rsp_data.blue !== ex.blue)
               $display("%0t blue exp %h got %h", $time, ex.blue, rsp_data.blue);
            if (rsp_data !== ex) errors++;
         end
      end
   end

   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(idx) << CSR_IDX_BIT;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (idx == REG_PITCH_SAT) cfg_sat = val & 32'h1FFFF;
      else cfg_val = val & 32'h1FFFF;
   endtask

   // offer one item and hold it until accepted
   task automatic send_pixel(input pixel_req_type px);
      req_valid <= 1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      colour_queue.push_back(colour_of(px));
   endtask

   task automatic drain();
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic pixel_req_type mk(input logic c, input logic [15:0] h,
                                        input logic [16:0] s, v, input logic [23:0] f);
      pixel_req_type p;
      p.command = c; p.hue = h; p.saturation = s; p.brightness = v; p.frequency = f;
      return p;
   endfunction

   function automatic pixel_req_type rand_pixel();
      pixel_req_type p;
      int k;
      p.command = 1'($urandom_range(0, 1));
      p.hue = 16'($urandom);
      k = $urandom_range(0, 7);
      p.saturation = k == 0 ? 17'h1FFFF : k == 1 ? ONE : 17'($urandom_range(0, 65536));
      k = $urandom_range(0, 7);
      p.brightness = k == 0 ? 17'h1FFFF : k == 1 ? 17'd0 : 17'($urandom_range(0, 65536));
      k = $urandom_range(0, 3);
      p.frequency = k == 0 ? 24'(1 << $urandom_range(0, 23)) : 24'($urandom);
      return p;
   endfunction

   typedef struct {
      pixel_req_type px;
      bit            typed;
      pixel_rsp_type colour;
   } stim_row_type;

   stim_row_type directed[$];

   initial begin
      pixel_req_type p;
      pixel_rsp_type zero;
      int sent;
      zero = '0;
      req_valid = 0; req_data = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      cfg_sat = PITCH_SAT_RESET;
      cfg_val = PITCH_VAL_RESET;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero value gives black; zero saturation at full value gives white
      directed.push_back('{mk(CMD_HSV, 16'h1234, ONE, 17'd0, 24'hFFFFFF), 1, zero});
      directed.push_back('{mk(CMD_HSV, 16'hFFFF, 17'd0, ONE, 24'd0), 1, {ONE, ONE, ONE}});
      directed.push_back('{mk(CMD_HSV, 16'h0000, 17'h1FFFF, 17'h1FFFF, 24'd5), 0, zero});
      directed.push_back('{mk(CMD_HSV, 16'h5555, ONE, ONE, 24'd0), 0, zero});
      directed.push_back('{mk(CMD_HSV, 16'hAAAA, 17'h8000, 17'h8000, 24'd0), 0, zero});
      directed.push_back('{mk(CMD_HSV, 16'h8000, ONE, 17'd1, 24'd0), 0, zero});
      directed.push_back('{mk(CMD_HSV, 16'hFFFF, ONE, 17'hFFFF, 24'd0), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 24'd0), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'd0, 17'd0, 17'd0, 24'd255), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'd0, 17'd0, 17'd0, 24'd256), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'd0, 17'd0, 17'd0, 24'h800000), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'd0, 17'd0, 17'd0, 24'hFFFFFF), 0, zero});
      directed.push_back('{mk(CMD_FREQ, 16'd0, 17'd0, 17'd0, 24'h01B800), 0, zero});
      foreach (directed[i]) begin
         send_pixel(directed[i].px);
         if (directed[i].typed) colour_queue[$] = directed[i].colour;
      end
      req_valid <= 0;
      drain();

      // register extremes, each followed by frequency items
      for (int phase = 0; phase < 4; phase++) begin
         csr_write(REG_PITCH_SAT, phase == 0 ? 32'd0 : phase == 1 ? 32'h1FFFF :
                   phase == 2 ? 32'd65536 : $urandom_range(0, 65536));
         csr_write(REG_PITCH_VAL, phase == 0 ? 32'd65536 : phase == 1 ? 32'd0 :
                   phase == 2 ? 32'h1FFFF : $urandom_range(1, 65535));
         for (int i = 0; i < 6; i++) begin
            p = rand_pixel();
            p.command = CMD_FREQ;
            send_pixel(p);
         end
         req_valid <= 0;
         drain();
      end

      // random traffic in bursts; one long receiver hold-off midway
      sent = 0;
      while (sent < NUM_RANDOM) begin
         int burst;
         burst = $urandom_range(1, 40);
         if (sent >= 200) long_hold = 1;
         for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
            send_pixel(rand_pixel());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         if (sent >= 250 && sent < 290) begin
            req_valid <= 0;
            drain();
            csr_write(REG_PITCH_SAT, $urandom_range(0, 65536));
            csr_write(REG_PITCH_VAL, $urandom_range(0, 65536));
         end
      end
      req_valid <= 0;
      hold_rsp = 1;
      drain();
      $display("covered directed extremes, register settings and %0d random items",
               NUM_RANDOM);
      $display("%0d results checked", results_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[filelist.f]
design/bhr_pkg.sv
design/bhr_log2_pipe.sv
design/bhr_sqrt_pipe.sv
design/bhr_exp2_pipe.sv
design/balanced_hsv_to_rgb.sv
design/bhr_checker.sv
dv/balanced_hsv_to_rgb_tb.sv
